FILE: design/sus_pkg.sv
// Shared constants, operation codes and the cell control bundle for the sorted set.
`timescale 1ns / 1ps

package sus_pkg;

    localparam int CAPACITY = 32;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int DATA_W   = 32;
    localparam int COUNT_W  = 6;

    // Input command codes.
    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_DELETE = 1'b1;

    // Operations broadcast to every cell of the chain.
    localparam logic [1:0] OP_HOLD   = 2'd0;
    localparam logic [1:0] OP_INSERT = 2'd1;
    localparam logic [1:0] OP_DELETE = 2'd2;
    localparam logic [1:0] OP_ROTATE = 2'd3;

    typedef struct packed {
        logic [1:0]              op;
        logic signed [DATA_W-1:0] value;
        logic [CNT_W-1:0]        count;
    } cell_ctl_t;

endpackage

FILE: design/sorted_unique_set.sv
// Sorted set of distinct signed 32-bit values built as a chain of compare-and-shift cells.
// Usage:
// The input channel (in_valid, in_stall, command, value) takes one transaction per
// command: command 0 inserts value, command 1 deletes it. Inserting a present value
// or deleting an absent one leaves the set as it was; inserting a new value into a
// full set drops it and sets insert_dropped on the whole listing.
// After each command the output channel (out_valid, out_stall) lists the set in
// ascending order, one transaction per element with count, element, element_valid,
// insert_dropped and last. An empty set gives one transaction with count 0,
// element 0, element_valid 0 and last 1.
// Timing: a command is applied to all cells at once in the cycle after acceptance, and
// the first result appears in the cycle after that. The listing rotates the cell ring
// by one position per accepted result. in_stall stays high from acceptance until the
// last result of the listing has been taken.
// While out_stall is high the current result holds and the ring does not move.
// Reset empties the set; stored values need no clearing since the count masks them.
`timescale 1ns / 1ps

module sorted_unique_set (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic                              command,
    input  logic signed [sus_pkg::DATA_W-1:0] value,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [sus_pkg::COUNT_W-1:0]       count,
    output logic signed [sus_pkg::DATA_W-1:0] element,
    output logic                              element_valid,
    output logic                              insert_dropped,
    output logic                              last
);
    import sus_pkg::*;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_APPLY = 2'd1;
    localparam logic [1:0] ST_LIST  = 2'd2;

    logic [1:0]               state_reg, state_next;
    logic                     cmd_reg;
    logic signed [DATA_W-1:0] value_reg;
    logic [CNT_W-1:0]         count_reg, count_next;
    logic                     dropped_reg, dropped_next;
    logic [IDX_W-1:0]         pos_reg, pos_next;

    cell_ctl_t                ctl;
    logic                     present;
    logic                     is_last;
    logic                     out_take;

    logic signed [DATA_W-1:0] val_w [CAPACITY];
    logic                     lt_w  [CAPACITY];
    logic [CAPACITY-1:0]      eq_w;

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            logic                     lt_l;
            logic signed [DATA_W-1:0] v_l;
            logic signed [DATA_W-1:0] v_r;
            logic                     eq_c;

            if (gi == 0)
            begin : g_first
                assign lt_l = 1'b1;
                assign v_l  = '0;
            end
            else
            begin : g_inner
                assign lt_l = lt_w[gi-1];
                assign v_l  = val_w[gi-1];
            end

            if (gi == CAPACITY - 1)
            begin : g_top
                assign v_r = '0;
            end
            else
            begin : g_below
                assign v_r = val_w[gi+1];
            end

            sus_cell u_cell (
                .clk       (clk),
                .ctl       (ctl),
                .idx       (IDX_W'(gi)),
                .lt_left   (lt_l),
                .val_left  (v_l),
                .val_right (v_r),
                .head      (val_w[0]),
                .lt        (lt_w[gi]),
                .eq        (eq_c),
                .val       (val_w[gi])
            );

            assign eq_w[gi] = eq_c;
        end
    endgenerate

    assign present  = |eq_w;
    assign is_last  = (count_reg == '0) || ((CNT_W'(pos_reg) + CNT_W'(1)) == count_reg);
    assign out_take = (state_reg == ST_LIST) && !out_stall;

    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        dropped_next = dropped_reg;
        pos_next     = pos_reg;
        ctl.op       = OP_HOLD;
        ctl.value    = value_reg;
        ctl.count    = count_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_APPLY;
                end
            end
            ST_APPLY:
            begin
                dropped_next = 1'b0;
                pos_next     = '0;
                state_next   = ST_LIST;
                if (cmd_reg == CMD_INSERT)
                begin
                    if (!present)
                    begin
                        if (count_reg == CNT_W'(CAPACITY))
                        begin
                            dropped_next = 1'b1;
                        end
                        else
                        begin
                            ctl.op     = OP_INSERT;
                            count_next = count_reg + CNT_W'(1);
                        end
                    end
                end
                else if (present)
                begin
                    ctl.op     = OP_DELETE;
                    count_next = count_reg - CNT_W'(1);
                end
            end
            ST_LIST:
            begin
                if (!out_stall)
                begin
                    ctl.op = OP_ROTATE;
                    if (is_last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        pos_next = pos_reg + IDX_W'(1);
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            dropped_reg <= 1'b0;
            pos_reg     <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            dropped_reg <= dropped_next;
            pos_reg     <= pos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && in_valid)
        begin
            cmd_reg   <= command;
            value_reg <= value;
        end
    end

    assign in_stall       = (state_reg != ST_IDLE);
    assign out_valid      = (state_reg == ST_LIST);
    assign count          = COUNT_W'(count_reg);
    assign element_valid  = (count_reg != '0);
    assign element        = element_valid ? val_w[0] : '0;
    assign insert_dropped = dropped_reg;
    assign last           = is_last;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("set count above capacity");

    a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LIST && dropped_reg) |-> (count_reg == CNT_W'(CAPACITY)))
        else $error("insert dropped while set not full");

    a_ascending: assert property (@(posedge clk) disable iff (!rst_n)
        (out_take && !is_last) |=>
            (out_valid && ($signed(element) > $signed($past(element)))))
        else $error("listing not strictly ascending");

    a_list_end: assert property (@(posedge clk) disable iff (!rst_n)
        (out_take && is_last) |=> (state_reg == ST_IDLE))
        else $error("listing did not end after last result");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_APPLY) |=>
            (count_reg == $past(count_reg) ||
             count_reg == $past(count_reg) + CNT_W'(1) ||
             count_reg == $past(count_reg) - CNT_W'(1)))
        else $error("count changed by more than one");

endmodule

FILE: design/sus_cell.sv
// One storage cell of the sorted chain: compares, shifts and rotates with its neighbors.
`timescale 1ns / 1ps

module sus_cell (
    input  logic                           clk,
    input  sus_pkg::cell_ctl_t             ctl,
    input  logic [sus_pkg::IDX_W-1:0]      idx,
    input  logic                           lt_left,
    input  logic signed [sus_pkg::DATA_W-1:0] val_left,
    input  logic signed [sus_pkg::DATA_W-1:0] val_right,
    input  logic signed [sus_pkg::DATA_W-1:0] head,
    output logic                           lt,
    output logic                           eq,
    output logic signed [sus_pkg::DATA_W-1:0] val
);
    import sus_pkg::*;

    logic signed [DATA_W-1:0] val_reg;
    logic signed [DATA_W-1:0] val_next;
    logic [CNT_W-1:0]         idx_ext;
    logic [CNT_W-1:0]         idx_inc;
    logic                     occupied;

    assign idx_ext  = CNT_W'(idx);
    assign idx_inc  = idx_ext + CNT_W'(1);
    assign occupied = idx_ext < ctl.count;
    assign lt       = occupied && ($signed(val_reg) < $signed(ctl.value));
    assign eq       = occupied && (val_reg == ctl.value);
    assign val      = val_reg;

    always_comb
    begin
        val_next = val_reg;
        case (ctl.op)
            OP_INSERT:
            begin
                // The first cell not below the new value takes it; the ones above move up.
                if (idx_ext <= ctl.count && !lt)
                begin
                    val_next = lt_left ? ctl.value : val_left;
                end
            end
            OP_DELETE:
            begin
                if (!lt && idx_inc < ctl.count)
                begin
                    val_next = val_right;
                end
            end
            OP_ROTATE:
            begin
                // The occupied cells form a ring; the top one refills from the head.
                if (occupied)
                begin
                    val_next = (idx_inc == ctl.count) ? head : val_right;
                end
            end
            default:
            begin
                val_next = val_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

endmodule

FILE: tb/tb_sorted_unique_set.sv
// Self-checking testbench for the sorted set: queued command driver, listing predictor and monitor.
`timescale 1ns / 1ps

module tb_sorted_unique_set;
    import sus_pkg::*;

    typedef struct packed {
        logic                     cmd;
        logic signed [DATA_W-1:0] val;
        logic                     wait_idle;
    } command_item_t;

    typedef struct packed {
        logic [COUNT_W-1:0]       cnt;
        logic signed [DATA_W-1:0] elem;
        logic                     elem_valid;
        logic                     dropped;
        logic                     is_last;
    } listing_entry_t;

    localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
    localparam int DRAIN_CYCLES = CAPACITY + 8;

    logic                       clk;
    logic                       rst_n;
    logic                       in_valid;
    logic                       in_stall;
    logic                       command;
    logic signed [DATA_W-1:0]   value;
    logic                       out_valid;
    logic                       out_stall;
    logic [COUNT_W-1:0]         count;
    logic signed [DATA_W-1:0]   element;
    logic                       element_valid;
    logic                       insert_dropped;
    logic                       last;

    command_item_t              pending_commands[$];
    listing_entry_t             expected_listing[$];
    logic signed [DATA_W-1:0]   stored_values[$];
    logic signed [DATA_W-1:0]   set_vals[CAPACITY];
    int                         set_size;
    int                         n_issued;
    int                         n_accepted;
    int                         error_count;
    logic                       calm;

    sorted_unique_set DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .command        (command),
        .value          (value),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .count          (count),
        .element        (element),
        .element_valid  (element_valid),
        .insert_dropped (insert_dropped),
        .last           (last)
    );

    // Neither side idles during this stretch of commands.
    assign calm = (n_issued >= 100) && (n_issued < 160);

    initial
    begin
        clk       = 1'b0;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        out_stall = 1'b0;
        command   = CMD_INSERT;
        value     = '0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
    end

    initial
    begin
        forever #4 clk = ~clk;
    end

    initial
    begin
        #4_000_000;
        $display("== FAIL ==");
        $finish;
    end

    task automatic report_mismatch(input string what);
        error_count++;
        $display("[%0t] mismatch: %s", $time, what);
    endtask

    // Updates the set for one command and queues the listing it produces.
    task automatic apply_command(input logic cmd, input logic signed [DATA_W-1:0] val);
        int             pos;
        int             i;
        logic           present;
        logic           dropped;
        listing_entry_t entry;
        pos     = 0;
        dropped = 1'b0;
        while (pos < set_size && set_vals[pos] < val)
            pos++;
        present = (pos < set_size) && (set_vals[pos] == val);
        if (cmd == CMD_INSERT)
        begin
            if (!present)
            begin
                if (set_size >= CAPACITY)
                    dropped = 1'b1;
                else
                begin
                    for (i = set_size; i > pos; i--)
                        set_vals[i] = set_vals[i - 1];
                    set_vals[pos] = val;
                    set_size++;
                end
            end
        end
        else if (present)
        begin
            for (i = pos; i + 1 < set_size; i++)
                set_vals[i] = set_vals[i + 1];
            set_size--;
        end

        if (set_size == 0)
        begin
            entry = '{cnt: '0, elem: '0, elem_valid: 1'b0, dropped: dropped, is_last: 1'b1};
            expected_listing.push_back(entry);
        end
        else
        begin
            for (i = 0; i < set_size; i++)
            begin
                entry.cnt        = set_size[COUNT_W-1:0];
                entry.elem       = set_vals[i];
                entry.elem_valid = 1'b1;
                entry.dropped    = dropped;
                entry.is_last    = (i == set_size - 1);
                expected_listing.push_back(entry);
            end
        end
    endtask

    function automatic logic signed [DATA_W-1:0] pick_value();
        int pool;
        pool = $urandom_range(0, 9);
        if (pool < 4)
            return $urandom_range(0, 40) - 20;
        if (pool == 4)
        begin
            case ($urandom_range(0, 5))
                0: return VAL_MIN;
                1: return VAL_MAX;
                2: return VAL_MIN + 1;
                3: return VAL_MAX - 1;
                4: return -1;
                default: return 0;
            endcase
        end
        return $urandom;
    endfunction

    task automatic queue_command(input logic cmd, input logic signed [DATA_W-1:0] val,
                                 input logic wait_idle = 1'b0);
        command_item_t item;
        item.cmd       = cmd;
        item.val       = val;
        item.wait_idle = wait_idle;
        pending_commands.push_back(item);
        if (cmd == CMD_INSERT)
            stored_values.push_back(val);
    endtask

    // Deletes a value inserted earlier with chance hit_percent, else a picked one, so the set really shrinks.
    task automatic queue_delete(input int hit_percent);
        int idx;
        logic signed [DATA_W-1:0] val;
        if (stored_values.size() != 0 && $urandom_range(0, 99) < hit_percent)
        begin
            idx = $urandom_range(0, stored_values.size() - 1);
            val = stored_values[idx];
            stored_values.delete(idx);
        end
        else
            val = pick_value();
        queue_command(CMD_DELETE, val);
    endtask

    task automatic queue_episode();
        int n;
        queue_command(CMD_INSERT, pick_value(), 1'b1);
        for (n = 0; n < 47; n++)
        begin
            if ($urandom_range(0, 9) == 0)
                queue_delete(90);
            else
                queue_command(CMD_INSERT, pick_value());
        end
        // The set should be full here: new values get dropped, duplicates are not flagged.
        for (n = 0; n < 16; n++)
        begin
            if ($urandom_range(0, 1) == 0 && stored_values.size() != 0)
                queue_command(CMD_INSERT,
                              stored_values[$urandom_range(0, stored_values.size() - 1)]);
            else
                queue_command(CMD_INSERT, pick_value());
        end
        for (n = 0; n < 45; n++)
        begin
            if ($urandom_range(0, 99) < 85)
                queue_delete(95);
            else
                queue_command(CMD_INSERT, pick_value());
        end
    endtask

    always @(negedge clk)
    begin : driver
        command_item_t nxt;
        if (!rst_n)
            in_valid <= 1'b0;
        else if (n_accepted == n_issued)
        begin
            if (pending_commands.size() == 0
                || (pending_commands[0].wait_idle && expected_listing.size() != 0)
                || (!calm && $urandom_range(0, 99) < 13))
                in_valid <= 1'b0;
            else
            begin
                nxt = pending_commands.pop_front();
                command  <= nxt.cmd;
                value    <= nxt.val;
                in_valid <= 1'b1;
                n_issued++;
            end
        end
    end

    always @(negedge clk)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
            out_stall <= !calm && ($urandom_range(0, 99) < 13);
    end

    // Results are checked before a new command is predicted in the same cycle,
    // so the expectation queue keeps its order whatever the event order.
    always @(posedge clk)
    begin : monitor
        listing_entry_t want;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_listing.size() == 0)
                    report_mismatch($sformatf("unexpected result, element %0d", element));
                else
                begin
                    want = expected_listing.pop_front();
                    if (count !== want.cnt)
                        report_mismatch($sformatf("count got %0d expected %0d",
                                                  count, want.cnt));
                    if (element !== want.elem)
                        report_mismatch($sformatf("element got %0d expected %0d",
                                                  element, want.elem));
                    if (element_valid !== want.elem_valid)
                        report_mismatch($sformatf("element_valid got %b expected %b",
                                                  element_valid, want.elem_valid));
                    if (insert_dropped !== want.dropped)
                        report_mismatch($sformatf("insert_dropped got %b expected %b",
                                                  insert_dropped, want.dropped));
                    if (last !== want.is_last)
                        report_mismatch($sformatf("last got %b expected %b",
                                                  last, want.is_last));
                end
            end
            if (in_valid && !in_stall)
            begin
                apply_command(command, value);
                n_accepted++;
            end
        end
    end

    initial
    begin : stimulus
        int n;
        set_size    = 0;
        n_issued    = 0;
        n_accepted  = 0;
        error_count = 0;

        // Absent delete on the empty set, extremes, duplicates, then back to empty.
        queue_command(CMD_DELETE, 5);
        queue_command(CMD_INSERT, -1);
        queue_command(CMD_INSERT, VAL_MIN);
        queue_command(CMD_INSERT, VAL_MAX);
        queue_command(CMD_INSERT, 0);
        queue_command(CMD_INSERT, -1);
        queue_command(CMD_INSERT, VAL_MIN);
        queue_command(CMD_DELETE, 7);
        queue_command(CMD_DELETE, -1);
        queue_command(CMD_INSERT, 32'sh5555_5555);
        queue_command(CMD_INSERT, 32'shAAAA_AAAA);
        queue_command(CMD_INSERT, VAL_MIN + 1);
        queue_command(CMD_INSERT, VAL_MAX - 1);
        queue_command(CMD_DELETE, VAL_MAX);
        queue_command(CMD_DELETE, VAL_MIN);
        queue_command(CMD_DELETE, 0);
        queue_command(CMD_DELETE, 32'sh5555_5555);
        queue_command(CMD_DELETE, 32'shAAAA_AAAA);
        queue_command(CMD_DELETE, VAL_MIN + 1);
        queue_command(CMD_DELETE, VAL_MAX - 1);
        queue_command(CMD_DELETE, VAL_MAX);
        stored_values.delete();

        queue_episode();
        queue_episode();
        for (n = 0; n < 25; n++)
        begin
            if ($urandom_range(0, 1) == 0)
                queue_delete(50);
            else
                queue_command(CMD_INSERT, pick_value());
        end

        while (pending_commands.size() != 0 || n_accepted != n_issued
               || expected_listing.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

FILE: files.f
design/sus_pkg.sv
design/sus_cell.sv
design/sorted_unique_set.sv
tb/tb_sorted_unique_set.sv
